// ===== hdl/tcnap_pkg.sv =====
// Package for the tile constraint narrow and pick block.
// Holds the item structs, fixed sizes and small helper functions; no dependencies.
`default_nettype none

package tcnap_pkg;

    localparam int unsigned MAX_TILES  = 8;
    localparam int unsigned DIRECTIONS = 4;
    localparam int unsigned CFG_IDX_W  = 8;

    localparam logic       OP_NARROW = 1'b0;
    localparam logic       OP_PICK   = 1'b1;

    typedef logic [63:0] allow_t;
    typedef logic [7:0]  tile_mask_t;

    typedef struct packed {
        logic       operation;
        tile_mask_t cell_mask;
        logic [3:0] neighbor_present;
        tile_mask_t neighbor_mask0;
        tile_mask_t neighbor_mask1;
        tile_mask_t neighbor_mask2;
        tile_mask_t neighbor_mask3;
        logic [15:0] random_value;
    } in_item_t;

    typedef struct packed {
        tile_mask_t result_mask;
        logic       changed;
        logic       contradiction;
        logic [2:0] picked_tile;
    } out_item_t;

    // Tiles i that at least one tile j of the neighbour allows (bit j*8+i).
    function automatic tile_mask_t support_vec(input tile_mask_t nb, input allow_t tbl);
        tile_mask_t acc;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                acc[i] = acc[i] | (nb[j] & tbl[j*8 + i]);
            end
        end
        return acc;
    endfunction

    // Remainder of a small digit sum by a small constant: restoring
    // subtract of m shifted down from 16*m; valid while x < 32*m.
    function automatic logic [2:0] mod_fold(input logic [5:0] x, input logic [3:0] m);
        logic [9:0] v;
        logic [9:0] step;
        v = {4'd0, x};
        for (int k = 4; k >= 0; k--) begin
            step = 10'(m) << k;
            if (v >= step) begin
                v = v - step;
            end
        end
        return v[2:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tile_constraint_narrow_and_pick.sv =====
// Takes one item per cycle while m_ready does not hold back the output.
// Three register stages (support/digit sums, narrow/remainder, select/output), each
// with its own valid bit; the first loads at the accepting edge. A stage refills as
// soon as it empties, so an item is taken while a finished result still waits on m_ready.
// Reset (aresetn low, synchronous) empties all stages and clears the allow tables.
// cfg_ready is always high; writes to indexes above 3 are dropped.
`default_nettype none

module tile_constraint_narrow_and_pick
    import tcnap_pkg::*;
#(
    parameter int unsigned TILE_COUNT = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire allow_t               cfg_data
);

    // Tiles at or above TILE_COUNT never take part.
    localparam logic [8:0] ALL_MASK_W = (9'd1 << TILE_COUNT) - 9'd1;
    localparam tile_mask_t ALL_MASK   = ALL_MASK_W[7:0];

    // ------------------------------------------------------------------
    // Allow tables
    // ------------------------------------------------------------------
    allow_t allow_reg [DIRECTIONS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < DIRECTIONS; d++) begin
                allow_reg[d] <= '0;
            end
        end else if (cfg_valid && cfg_index < CFG_IDX_W'(DIRECTIONS)) begin
            allow_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when empty or when it hands on
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic s1_load, s2_load, s3_load;

    assign s3_load = !m_valid_reg || m_ready;
    assign s2_load = !s2_valid_reg || s3_load;
    assign s1_load = !s1_valid_reg || s2_load;
    assign s_ready = s1_load;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_load) s1_valid_reg <= s_valid;
            if (s2_load) s2_valid_reg <= s1_valid_reg;
            if (s3_load) m_valid_reg  <= s2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: mask tiles, per-direction support, popcount, digit sums
    // ------------------------------------------------------------------
    tile_mask_t cell_in;
    tile_mask_t nb_in [DIRECTIONS];
    tile_mask_t sup_next [DIRECTIONS];
    logic [3:0] count_next;
    logic [4:0] sum3_next;   // base-4 digits: 4 = 1 mod 3
    logic [5:0] sum5_next;   // hex digits: 16 = 1 mod 5
    logic [5:0] sum7_next;   // octal digits: 8 = 1 mod 7

    always_comb begin
        cell_in  = s_data.cell_mask & ALL_MASK;
        nb_in[0] = s_data.neighbor_mask0 & ALL_MASK;
        nb_in[1] = s_data.neighbor_mask1 & ALL_MASK;
        nb_in[2] = s_data.neighbor_mask2 & ALL_MASK;
        nb_in[3] = s_data.neighbor_mask3 & ALL_MASK;
        // neighbour in direction d is checked against the opposite table
        for (int d = 0; d < DIRECTIONS; d++) begin
            sup_next[d] = support_vec(nb_in[d], allow_reg[(d + 2) % DIRECTIONS]);
        end
        count_next = '0;
        for (int i = 0; i < MAX_TILES; i++) begin
            count_next = count_next + 4'(cell_in[i]);
        end
        sum3_next = '0;
        for (int i = 0; i < 8; i++) begin
            sum3_next = sum3_next + 5'(s_data.random_value[2*i +: 2]);
        end
        sum5_next = '0;
        for (int i = 0; i < 4; i++) begin
            sum5_next = sum5_next + 6'(s_data.random_value[4*i +: 4]);
        end
        sum7_next = 6'(s_data.random_value[15]);
        for (int i = 0; i < 5; i++) begin
            sum7_next = sum7_next + 6'(s_data.random_value[3*i +: 3]);
        end
    end

    logic       s1_op_reg;
    tile_mask_t s1_cell_reg;
    logic [3:0] s1_present_reg;
    tile_mask_t s1_sup_reg [DIRECTIONS];
    logic [3:0] s1_count_reg;
    logic [4:0] s1_sum3_reg;
    logic [5:0] s1_sum5_reg;
    logic [5:0] s1_sum7_reg;
    logic [2:0] s1_rlow_reg;

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_op_reg      <= s_data.operation;
            s1_cell_reg    <= cell_in;
            s1_present_reg <= s_data.neighbor_present;
            for (int d = 0; d < DIRECTIONS; d++) begin
                s1_sup_reg[d] <= sup_next[d];
            end
            s1_count_reg   <= count_next;
            s1_sum3_reg    <= sum3_next;
            s1_sum5_reg    <= sum5_next;
            s1_sum7_reg    <= sum7_next;
            s1_rlow_reg    <= s_data.random_value[2:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: narrowed mask and random value modulo candidate count
    // ------------------------------------------------------------------
    tile_mask_t narrow_next;
    logic [2:0] r3, r5, r7, r6, k_next;

    always_comb begin
        narrow_next = s1_cell_reg;
        for (int d = 0; d < DIRECTIONS; d++) begin
            if (s1_present_reg[d]) begin
                narrow_next = narrow_next & s1_sup_reg[d];
            end
        end
        r3 = mod_fold({1'b0, s1_sum3_reg}, 4'd3);
        r5 = mod_fold(s1_sum5_reg, 4'd5);
        r7 = mod_fold(s1_sum7_reg, 4'd7);
        // mod 6 from mod 2 and mod 3
        r6 = (r3[0] == s1_rlow_reg[0]) ? r3 : r3 + 3'd3;
        unique case (s1_count_reg)
            4'd2:    k_next = {2'b00, s1_rlow_reg[0]};
            4'd3:    k_next = r3;
            4'd4:    k_next = {1'b0, s1_rlow_reg[1:0]};
            4'd5:    k_next = r5;
            4'd6:    k_next = r6;
            4'd7:    k_next = r7;
            4'd8:    k_next = s1_rlow_reg;
            default: k_next = 3'd0;   // one candidate, or empty
        endcase
    end

    logic       s2_op_reg;
    tile_mask_t s2_cell_reg;
    tile_mask_t s2_narrow_reg;
    logic [2:0] s2_k_reg;

    always_ff @(posedge aclk) begin
        if (s2_load) begin
            s2_op_reg     <= s1_op_reg;
            s2_cell_reg   <= s1_cell_reg;
            s2_narrow_reg <= narrow_next;
            s2_k_reg      <= k_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: pass the narrowed mask or choose the k-th candidate, form the result item
    // ------------------------------------------------------------------
    out_item_t  res_next;
    logic [3:0] seen;
    logic       found;

    always_comb begin
        res_next = '0;
        seen     = '0;
        found    = 1'b0;
        if (s2_op_reg == OP_NARROW) begin
            res_next.result_mask   = s2_narrow_reg;
            res_next.changed       = (s2_narrow_reg != s2_cell_reg);
            res_next.contradiction = (s2_narrow_reg == '0);
        end else begin
            res_next.contradiction = (s2_cell_reg == '0);
            for (int i = 0; i < MAX_TILES; i++) begin
                if (s2_cell_reg[i] && !found) begin
                    if (seen == {1'b0, s2_k_reg}) begin
                        found                = 1'b1;
                        res_next.picked_tile = 3'(i);
                        res_next.result_mask = tile_mask_t'(1) << i;
                    end
                    seen = seen + 4'd1;
                end
            end
        end
    end

    out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (s3_load) begin
            m_data_reg <= res_next;
        end
    end

    assign m_data = m_data_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_contra_iff_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.contradiction == (m_data.result_mask == '0)))
        else $error("contradiction flag disagrees with result mask");

    a_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.result_mask & ~ALL_MASK) == '0))
        else $error("result holds a tile beyond the tile count");

    a_pick_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.picked_tile != 3'd0
            |-> (m_data.result_mask == (tile_mask_t'(1) << m_data.picked_tile)))
        else $error("picked tile does not match result mask");

    a_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> s1_valid_reg)
        else $error("accepted item missing from first stage");

endmodule

`default_nettype wire
